### sv/pbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_pkg
// Types, codes and the gamma curve shared by the strip bit-plane packer.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int CFG_W  = 12;
  localparam int BASE_W = 18;
  localparam int COLOR_BYTES = 3;
  localparam int RGB_BITS  = COLOR_BYTES * 8;
  localparam int RGBW_BITS = 32;
  localparam int RAW_BITS  = 8;

  localparam logic [1:0] REG_GAMMA_ENABLE = 2'd0;
  localparam logic [1:0] REG_SNAKE_LENGTH = 2'd1;
  localparam logic [1:0] REG_SNAKE_OFFSET = 2'd2;

  localparam logic [2:0] OP_RGB   = 3'd0;
  localparam logic [2:0] OP_RGBW  = 3'd1;
  localparam logic [2:0] OP_SNAKE = 3'd2;
  localparam logic [2:0] OP_RAW   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FAIL  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  strip;
    logic [11:0] led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic [7:0]  data_byte;
    logic [12:0] word_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BASE_W-1:0] base;
    logic [5:0]        nbits;
    logic [31:0]       value;
    logic [3:0]        strip;
  } cmd_t;

  localparam logic [7:0] GAMMA_ROM [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
    8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
    8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,
    8'd16,8'd16,
    8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,
    8'd24,8'd25,
    8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,
    8'd35,8'd36,
    8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,
    8'd50,8'd50,
    8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,
    8'd67,8'd68,
    8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,
    8'd87,8'd89,
    8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,8'd102,8'd104,8'd105,8'd107,8'd109,
    8'd110,8'd112,8'd114,
    8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,8'd129,8'd131,8'd133,8'd135,
    8'd137,8'd138,8'd140,8'd142,
    8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,8'd160,8'd162,8'd164,8'd167,
    8'd169,8'd171,8'd173,8'd175,
    8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,8'd196,8'd198,8'd200,8'd203,
    8'd205,8'd208,8'd210,8'd213,
    8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,8'd236,8'd239,8'd241,8'd244,
    8'd247,8'd249,8'd252,8'd255
  };

endpackage
`default_nettype wire

### sv/parallel_strip_bitplane_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_strip_bitplane_packer
// Bit-transposed frame buffer for parallel LED strips with pixel, raw byte
// and read operations.
// ----------------------------------------------------------------------------
// A write of n bits reads and writes back one memory word per bit; a read
// reads one word, and a skipped item does not touch the memory. Serpentine
// items also go through the bit-serial divider and the multiply step in the
// front part. The back part takes a new command only once the result of the
// last one is registered. After reset the memory is cleared one word a cycle,
// all FRAME_WORDS words, with full high; the registers reset at once.
module parallel_strip_bitplane_packer #(
  parameter int FRAME_WORDS = 8192,
  parameter int LEAD_WORDS  = 4,
  parameter int STRIPS      = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  pbp_pkg::in_item_t          in_data,
  output logic                       empty,
  input  wire                        pop,
  output pbp_pkg::out_item_t         out_data,
  input  wire                        cfg_write,
  input  wire  [1:0]                 cfg_index,
  input  wire  [pbp_pkg::CFG_W-1:0]  cfg_data
);
  import pbp_pkg::*;

  logic clearing;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  pbp_front #(
    .FRAME_WORDS(FRAME_WORDS), .LEAD_WORDS(LEAD_WORDS), .STRIPS(STRIPS)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .clearing(clearing), .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  pbp_cmd_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wr_data(q_wdata), .full(q_full),
    .rd(q_pop), .rd_data(q_rdata), .empty(q_empty)
  );

  pbp_back #(.FRAME_WORDS(FRAME_WORDS)) u_back (
    .clk(clk), .rst(rst), .clearing(clearing), .q_data(q_rdata),
    .q_empty(q_empty), .q_pop(q_pop), .empty(empty), .pop(pop),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

### sv/pbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_front
// Accepts items, holds the configuration, maps serpentine indices with a
// bit-serial divider and turns each item into a frame buffer command.
// ----------------------------------------------------------------------------
module pbp_front #(
  parameter int FRAME_WORDS = 8192,
  parameter int LEAD_WORDS  = 4,
  parameter int STRIPS      = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  output logic                        full,
  input  pbp_pkg::in_item_t           in_data,
  input  wire                         cfg_write,
  input  wire  [1:0]                  cfg_index,
  input  wire  [pbp_pkg::CFG_W-1:0]   cfg_data,
  input  wire                         clearing,
  output logic                        q_push,
  input  wire                         q_full,
  output pbp_pkg::cmd_t               q_data
);
  import pbp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]  state;
  in_item_t    item;
  logic        gamma_enable;
  logic [11:0] snake_length;
  logic [11:0] snake_offset;
  logic [12:0] dividend;
  logic [12:0] quo;
  logic [11:0] rem;
  logic [3:0]  div_cnt;
  logic [13:0] pix;
  cmd_t        cmd;
  cmd_t        cmd_next;

  logic [11:0] len;
  logic [12:0] rem_sh;
  logic        take;
  logic [7:0]  gr, gg, gb, gw, gd;
  logic [BASE_W-1:0] base;

  assign len    = (snake_length == 12'd0) ? 12'd1 : snake_length;
  assign rem_sh = {rem, dividend[12]};
  assign take   = rem_sh >= {1'b0, len};
  assign full   = (state != S_IDLE) || clearing;
  assign q_push = (state == S_PUSH) && !q_full;
  assign q_data = cmd;

  always_comb begin
    gr = gamma_enable ? GAMMA_ROM[item.red]       : item.red;
    gg = gamma_enable ? GAMMA_ROM[item.green]     : item.green;
    gb = gamma_enable ? GAMMA_ROM[item.blue]      : item.blue;
    gw = gamma_enable ? GAMMA_ROM[item.white]     : item.white;
    gd = gamma_enable ? GAMMA_ROM[item.data_byte] : item.data_byte;
    base = '0;
    cmd_next.kind  = CMD_FAIL;
    cmd_next.nbits = 6'd0;
    cmd_next.value = 32'd0;
    cmd_next.strip = item.strip;
    case (item.opcode)
      OP_RGB, OP_SNAKE: begin
        base = BASE_W'(pix) * BASE_W'(RGB_BITS) + BASE_W'(LEAD_WORDS);
        cmd_next.nbits = 6'(RGB_BITS);
        cmd_next.value = {gr, gg, gb, 8'd0};
        cmd_next.kind  = CMD_WRITE;
      end
      OP_RGBW: begin
        base = BASE_W'(item.led_index) * BASE_W'(RGBW_BITS) + BASE_W'(LEAD_WORDS);
        cmd_next.nbits = 6'(RGBW_BITS);
        cmd_next.value = {gg, gr, gb, gw};
        cmd_next.kind  = CMD_WRITE;
      end
      OP_RAW: begin
        base = BASE_W'(item.led_index) * BASE_W'(RAW_BITS) + BASE_W'(LEAD_WORDS);
        cmd_next.nbits = 6'(RAW_BITS);
        cmd_next.value = {gd, 24'd0};
        cmd_next.kind  = CMD_WRITE;
      end
      OP_READ: begin
        base = BASE_W'(item.word_address);
        cmd_next.kind = (32'(item.word_address) < FRAME_WORDS) ? CMD_READ : CMD_FAIL;
      end
      default: begin
        cmd_next.kind = CMD_FAIL;
      end
    endcase
    if (cmd_next.kind == CMD_WRITE) begin
      if ((32'(item.strip) >= STRIPS) ||
          (32'(base) + 32'(cmd_next.nbits) >= FRAME_WORDS)) begin
        cmd_next.kind = CMD_FAIL;
      end
    end
    cmd_next.base = base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gamma_enable <= 1'b1;
      snake_length <= 12'd1;
      snake_offset <= 12'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAMMA_ENABLE: gamma_enable <= cfg_data[0];
          REG_SNAKE_LENGTH: snake_length <= cfg_data;
          REG_SNAKE_OFFSET: snake_offset <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (push && !full) begin
            item     <= in_data;
            pix      <= {2'b00, in_data.led_index};
            dividend <= 13'(snake_offset) + 13'(in_data.led_index);
            rem      <= 12'd0;
            quo      <= 13'd0;
            div_cnt  <= 4'd0;
            state    <= (in_data.opcode == OP_SNAKE) ? S_DIV : S_CALC;
          end
        end
        S_DIV: begin
          rem      <= take ? 12'(rem_sh - {1'b0, len}) : rem_sh[11:0];
          quo      <= {quo[11:0], take};
          dividend <= {dividend[11:0], 1'b0};
          div_cnt  <= div_cnt + 4'd1;
          if (div_cnt == 4'd12) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pix   <= 14'(quo) * 14'(len) +
                   (quo[0] ? 14'(len - rem - 12'd1) : 14'(rem));
          state <= S_CALC;
        end
        S_CALC: begin
          cmd   <= cmd_next;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/pbp_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_cmd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pbp_cmd_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            wr,
  input  pbp_pkg::cmd_t  wr_data,
  output logic           full,
  input  wire            rd,
  output pbp_pkg::cmd_t  rd_data,
  output logic           empty
);
  import pbp_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= !wptr;
      if (rd && !empty) rptr <= !rptr;
      count <= count + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

### sv/pbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_back
// Owns the frame buffer memory, clears it after reset and carries out each write
// command by read-modify-write of one word per bit; every result is registered.
// ----------------------------------------------------------------------------
module pbp_back #(
  parameter int FRAME_WORDS = 8192
) (
  input  wire                 clk,
  input  wire                 rst,
  output logic                clearing,
  input  pbp_pkg::cmd_t       q_data,
  input  wire                 q_empty,
  output logic                q_pop,
  output logic                empty,
  input  wire                 pop,
  output pbp_pkg::out_item_t  out_data
);
  import pbp_pkg::*;

  localparam int AW = $clog2(FRAME_WORDS);

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_RDREQ = 3'd2;
  localparam logic [2:0] B_MOD   = 3'd3;
  localparam logic [2:0] B_RESP  = 3'd4;

  logic [15:0] mem [FRAME_WORDS];
  logic [15:0] rdata;
  logic [2:0]  state;
  cmd_t        cmd;
  logic [AW-1:0] addr;
  logic [AW-1:0] clr;
  logic [5:0]  done;
  logic [31:0] val;
  logic        out_valid;
  out_item_t   res;
  out_item_t   pend_res;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   mask;
  logic          out_free;

  assign clearing = state == B_CLEAR;
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_data = res;
  assign out_free = !out_valid || pop;
  assign mask     = 16'd1 << cmd.strip;

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = (rdata & ~mask) | (val[31] ? mask : 16'd0);
    if (state == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = 16'd0;
    end else if (state == B_MOD && cmd.kind == CMD_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && (state != B_RESP)) out_valid <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == FRAME_WORDS - 1) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_data;
            addr  <= q_data.base[AW-1:0];
            val   <= q_data.value;
            done  <= 6'd0;
            state <= (q_data.kind == CMD_FAIL) ? B_RESP : B_RDREQ;
            pend_res.read_data <= 16'd0;
            pend_res.status    <= q_data.kind == CMD_FAIL;
          end
        end
        B_RDREQ: begin
          state <= B_MOD;
        end
        B_MOD: begin
          if (cmd.kind == CMD_READ) begin
            pend_res.read_data <= rdata;
            state <= B_RESP;
          end else begin
            addr <= addr + 1'b1;
            val  <= {val[30:0], 1'b0};
            done <= done + 6'd1;
            state <= (done + 6'd1 == cmd.nbits) ? B_RESP : B_RDREQ;
          end
        end
        B_RESP: begin
          if (out_free) begin
            res       <= pend_res;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !q_pop) else $error("command taken during clear");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(res))) else $error("result lost");
  a_fail_skips_memory: assert property (@(posedge clk) disable iff (rst)
    (state == B_MOD) |-> (cmd.kind != CMD_FAIL)) else $error("failed command ran");
  a_write_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == B_MOD && cmd.kind == CMD_WRITE) |-> (done < cmd.nbits))
    else $error("write ran past its bit count");

endmodule
`default_nettype wire

### tb/sv/pbp_frame_checker.sv
// ----------------------------------------------------------------------------
// pbp_frame_checker
// Watches the item, result and register channels of the strip bit-plane
// packer, keeps its own copy of the frame buffer and registers, and compares
// every result item in order with the word or status that it predicts.
// ----------------------------------------------------------------------------
module pbp_frame_checker
  import pbp_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wire               full,
  input  in_item_t          in_data,
  input  wire               empty,
  input  wire               pop,
  input  out_item_t         out_data,
  input  wire               cfg_write,
  input  wire  [1:0]        cfg_index,
  input  wire  [CFG_W-1:0]  cfg_data,
  output int                fails,
  output int                pending,
  output int                checked,
  output int                skipped
);

  localparam int FRAME_WORDS = 8192;
  localparam int LEAD_WORDS  = 4;
  localparam int STRIPS      = 16;

  logic [15:0]      frame_copy [FRAME_WORDS];
  logic             gamma_on;
  logic [CFG_W-1:0] snake_len;
  logic [CFG_W-1:0] snake_off;
  out_item_t        awaited_results [$];

  assign pending = awaited_results.size();

  function automatic logic [7:0] gamma_byte(logic [7:0] b);
    return gamma_on ? GAMMA_ROM[b] : b;
  endfunction

  function automatic logic store_bits(int base, int nbits, logic [31:0] value,
                                      logic [3:0] strip);
    int w;
    if (strip >= STRIPS) return 1'b1;
    if (base + nbits >= FRAME_WORDS) return 1'b1;
    for (int i = 0; i < nbits; i++) begin
      w = base + nbits - 1 - i;
      frame_copy[w][strip] = value[i];
    end
    return 1'b0;
  endfunction

  function automatic out_item_t packed_result(in_item_t it);
    out_item_t r;
    logic [23:0] rgb;
    logic [31:0] rgbw;
    int len, a, row, col, pix;
    r.read_data = '0;
    r.status = 1'b1;
    rgb = {gamma_byte(it.red), gamma_byte(it.green), gamma_byte(it.blue)};
    case (it.opcode)
      OP_RGB: begin
        r.status = store_bits(it.led_index * RGB_BITS + LEAD_WORDS, RGB_BITS,
                              32'(rgb), it.strip);
      end
      OP_RGBW: begin
        rgbw = {gamma_byte(it.green), gamma_byte(it.red), gamma_byte(it.blue),
                gamma_byte(it.white)};
        r.status = store_bits(it.led_index * RGBW_BITS + LEAD_WORDS, RGBW_BITS,
                              rgbw, it.strip);
      end
      OP_SNAKE: begin
        len = (snake_len == 0) ? 1 : int'(snake_len);
        a = int'(snake_off) + int'(it.led_index);
        row = a / len;
        col = a % len;
        if (row % 2 == 1) col = len - col - 1;
        pix = row * len + col;
        r.status = store_bits(pix * RGB_BITS + LEAD_WORDS, RGB_BITS, 32'(rgb),
                              it.strip);
      end
      OP_RAW: begin
        r.status = store_bits(it.led_index * RAW_BITS + LEAD_WORDS, RAW_BITS,
                              32'(gamma_byte(it.data_byte)), it.strip);
      end
      OP_READ: begin
        if (it.word_address < FRAME_WORDS) begin
          r.read_data = frame_copy[it.word_address];
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < FRAME_WORDS; i++) frame_copy[i] = '0;
      gamma_on = 1'b1;
      snake_len = 1;
      snake_off = 0;
      awaited_results.delete();
      fails = 0;
      checked = 0;
      skipped = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAMMA_ENABLE: gamma_on = cfg_data[0];
          REG_SNAKE_LENGTH: snake_len = cfg_data;
          REG_SNAKE_OFFSET: snake_off = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        checked++;
        if (out_data.status) skipped++;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Unexpected result item: data %h status %b",
                                    out_data.read_data, out_data.status);
        end else begin
          want = awaited_results.pop_front();
          if (want.read_data !== out_data.read_data || want.status !== out_data.status) begin
            fails++;
            if (fails <= 10)
              $display("Mismatch: expected data %h status %b, got data %h status %b",
                       want.read_data, want.status, out_data.read_data, out_data.status);
          end
        end
      end
      if (push && !full) awaited_results.push_back(packed_result(in_data));
    end
  end

endmodule

### tb/sv/tb_parallel_strip_bitplane_packer.sv
// ----------------------------------------------------------------------------
// tb_parallel_strip_bitplane_packer
// Drives directed and random pixel, raw byte, read and unused-opcode items
// through the strip bit-plane packer under several register settings, with
// random gaps on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_parallel_strip_bitplane_packer;
  import pbp_pkg::*;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  in_item_t         in_data;
  logic             empty;
  logic             pop;
  out_item_t        out_data;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fails, pending, checked, skipped;
  int               sent_items, settings_used, quiet_cycles;

  parallel_strip_bitplane_packer DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pbp_frame_checker frame_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails),
    .pending(pending), .checked(checked), .skipped(skipped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_for(int n);
    return ((n / 24) % 4 == 3) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_for(sent_items);
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sent_items++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk) push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(logic gamma, logic [CFG_W-1:0] len,
                               logic [CFG_W-1:0] off);
    drain_and_settle();
    write_reg(REG_GAMMA_ENABLE, CFG_W'(gamma));
    write_reg(REG_SNAKE_LENGTH, len);
    write_reg(REG_SNAKE_OFFSET, off);
    settings_used++;
  endtask

  function automatic in_item_t make_item(logic [2:0] op, logic [3:0] strip,
                                         logic [11:0] idx, logic [12:0] addr);
    in_item_t it;
    it.opcode = op;
    it.strip = strip;
    it.led_index = idx;
    it.red = $urandom;
    it.green = $urandom;
    it.blue = $urandom;
    it.white = $urandom;
    it.data_byte = $urandom;
    it.word_address = addr;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    logic [2:0] op;
    logic [11:0] idx;
    logic [12:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = OP_RGB;
    else if (pick < 40) op = OP_RGBW;
    else if (pick < 55) op = OP_SNAKE;
    else if (pick < 67) op = OP_RAW;
    else if (pick < 95) op = OP_READ;
    else op = $urandom_range(5, 7);
    idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
    addr = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1400));
    it = make_item(op, $urandom, idx, addr);
    return it;
  endfunction

  initial begin
    push = 1'b0;
    pop = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_items = 0;
    settings_used = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_reg(2'd3, '1);
    apply_setting(1'b1, 12'd5, 12'd2);
    send_item(make_item(OP_RGB, 4'd0, 12'd0, 13'd0));
    send_item(make_item(OP_RGB, 4'd15, 12'd340, 13'd0));
    send_item(make_item(OP_RGB, 4'd3, 12'd341, 13'd0));
    send_item(make_item(OP_RGB, 4'd7, 12'd4095, 13'd0));
    send_item(make_item(OP_RGBW, 4'd15, 12'd254, 13'd0));
    send_item(make_item(OP_RGBW, 4'd1, 12'd255, 13'd0));
    send_item(make_item(OP_RAW, 4'd15, 12'd1022, 13'd0));
    send_item(make_item(OP_RAW, 4'd2, 12'd1023, 13'd0));
    send_item(make_item(OP_SNAKE, 4'd4, 12'd0, 13'd0));
    send_item(make_item(OP_SNAKE, 4'd5, 12'd4, 13'd0));
    send_item(make_item(OP_SNAKE, 4'd6, 12'd4095, 13'd0));
    send_item(make_item(3'd5, 4'd0, 12'd0, 13'd0));
    send_item(make_item(3'd7, 4'd9, 12'd1, 13'd8191));
    for (int w = 0; w < 8; w++)
      send_item(make_item(OP_READ, 4'd0, 12'd0, 13'(w)));
    send_item(make_item(OP_READ, 4'd0, 12'd0, 13'd8191));
    send_item(make_item(OP_READ, 4'd0, 12'd0, 13'd8187));

    apply_setting(1'b1, 12'd1, 12'd0);
    repeat (100) send_item(random_item());
    apply_setting(1'b0, 12'd4095, 12'd0);
    repeat (100) send_item(random_item());
    apply_setting(1'b1, 12'd0, 12'd4095);
    repeat (60) send_item(random_item());
    apply_setting(1'b0, 12'($urandom_range(1, 16)), 12'($urandom_range(0, 64)));
    repeat (140) send_item(random_item());

    drain_and_settle();
    $display("Sent %0d items under %0d register settings; %0d results checked,",
             sent_items, settings_used, checked);
    $display("%0d of them out of range or unused operations.", skipped);
    if (fails == 0) begin
      $display("** parallel_strip_bitplane_packer: PASSED **");
    end else begin
      $display("** parallel_strip_bitplane_packer: FAILED **");
    end
    $finish;
  end

  initial begin
    int taken, gap;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = gap_for(taken + 7);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_write || rst) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 30000) begin
        $display("Timeout: no item moved for %0d cycles.", quiet_cycles);
        $display("** parallel_strip_bitplane_packer: FAILED **");
        $finish;
      end
    end
  end

endmodule
